/* rtl/core/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication on clk, switched off while rst_n is low
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on clk, switched off while rst_n is low
`define ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/pidaw_pkg.sv */
package pidaw_pkg;

    // Number format
    localparam int FRAC_BITS          = 16;
    localparam int ALPHA_BITS         = 16;
    localparam int DERIV_FILTER_ALPHA = 65536;

    localparam int WORD_W    = 32;
    localparam int STEP_W    = 17;
    localparam int CFG_IDX_W = 3;

    // Shared multiplier: signed operands, product kept at 64 bits
    localparam int MUL_W  = 34;
    localparam int PROD_W = 64;
    // Rounded products plus room for a three-term sum
    localparam int SUM_W  = PROD_W - FRAC_BITS + 2;

    // Rate divider: |error difference| < 2^32, shifted up by FRAC_BITS
    localparam int NUM_W     = WORD_W + FRAC_BITS;
    localparam int DIV_STEPS = (NUM_W + 1) / 2;
    localparam int QUO_W     = 2 * DIV_STEPS;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [STEP_W-1:0]        step_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_W - 1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_W - 1){1'b0}}};

    // Period used when step_time reads zero (0.01 s)
    localparam step_t STEP_FALLBACK = STEP_W'(((1 << FRAC_BITS) + 50) / 100);
    localparam logic [ALPHA_BITS:0] ALPHA_Q = (ALPHA_BITS + 1)'(DERIV_FILTER_ALPHA);

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P        = 3'd0,
        REG_GAIN_I        = 3'd1,
        REG_GAIN_D        = 3'd2,
        REG_STEP_TIME     = 3'd3,
        REG_INTEGRAL_LOW  = 3'd4,
        REG_INTEGRAL_HIGH = 3'd5,
        REG_DRIVE_LOW     = 3'd6,
        REG_DRIVE_HIGH    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        word_t gain_p;
        word_t gain_i;
        word_t gain_d;
        step_t step_time;
        word_t integral_low;
        word_t integral_high;
        word_t drive_low;
        word_t drive_high;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        gain_p:        word_t'(65536),
        gain_i:        word_t'(0),
        gain_d:        word_t'(0),
        step_time:     step_t'(655),
        integral_low:  word_t'(-65536000),
        integral_high: word_t'(65536000),
        drive_low:     word_t'(-65536000),
        drive_high:    word_t'(65536000)
    };

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_DIV_INIT,
        S_DIV_STEP,
        S_DIV_FIN,
        S_FLT_MUL,
        S_FLT_ADD,
        S_INT_MUL,
        S_INT_ADD,
        S_P,
        S_D,
        S_I,
        S_CHECK,
        S_I2,
        S_DONE,
        S_CLEAR
    } ctrl_state_t;

    // Datapath register operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ERR,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_FIN,
        OP_FLT_ADD,
        OP_INT_ADD,
        OP_P,
        OP_D,
        OP_I,
        OP_RETRY,
        OP_COMMIT,
        OP_CLEAR
    } dp_op_t;

    // Multiplier operand pairs
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_FLT,
        MUL_INT,
        MUL_P,
        MUL_D,
        MUL_I,
        MUL_I_OLD
    } mul_sel_t;

    typedef struct packed {
        dp_op_t   op;
        mul_sel_t mul_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic rate_ready;
        logic windup;
    } dp_status_t;

endpackage

/* rtl/core/pidaw_sample_if.sv */
interface pidaw_sample_if;
    import pidaw_pkg::*;

    logic  valid;
    logic  ready;
    logic  cmd;
    word_t setpoint;
    word_t measured;

    modport source (output valid, output cmd, output setpoint, output measured, input ready);
    modport sink   (input valid, input cmd, input setpoint, input measured, output ready);
endinterface

/* rtl/core/pidaw_result_if.sv */
interface pidaw_result_if;
    import pidaw_pkg::*;

    logic  valid;
    logic  ready;
    word_t drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

/* rtl/core/pidaw_cfg_if.sv */
interface pidaw_cfg_if;
    import pidaw_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/pidaw_cfg.sv */
module pidaw_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_valid,
    input  logic [pidaw_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [pidaw_pkg::WORD_W-1:0]   wr_data,
    output logic                           wr_ready,
    output pidaw_pkg::cfg_t                regs
);
    import pidaw_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;

    // Writes are always taken
    assign wr_ready = 1'b1;
    assign regs     = regs_reg;

    // Register decode
    always_comb
    begin
        regs_next = regs_reg;
        case (cfg_idx_t'(wr_index))
            REG_GAIN_P:        regs_next.gain_p        = wr_data;
            REG_GAIN_I:        regs_next.gain_i        = wr_data;
            REG_GAIN_D:        regs_next.gain_d        = wr_data;
            REG_STEP_TIME:     regs_next.step_time     = wr_data[STEP_W-1:0];
            REG_INTEGRAL_LOW:  regs_next.integral_low  = wr_data;
            REG_INTEGRAL_HIGH: regs_next.integral_high = wr_data;
            REG_DRIVE_LOW:     regs_next.drive_low     = wr_data;
            REG_DRIVE_HIGH:    regs_next.drive_high    = wr_data;
            default:           regs_next = regs_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= CFG_RESET;
        end
        else if (wr_valid)
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

/* rtl/core/pidaw_dp.sv */
`include "assert_macros.svh"

module pidaw_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pidaw_pkg::ctrl_cmd_t  cmd,
    input  pidaw_pkg::cfg_t       cfg,
    input  pidaw_pkg::word_t      setpoint,
    input  pidaw_pkg::word_t      measured,
    output pidaw_pkg::dp_status_t status,
    output pidaw_pkg::word_t      drive
);
    import pidaw_pkg::*;

    // Round to nearest, ties towards +inf, dropping FRAC_BITS
    function automatic logic signed [PROD_W-1:0] rnd_frac(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] biased;
        biased = x + (PROD_W'(1) << (FRAC_BITS - 1));
        return biased >>> FRAC_BITS;
    endfunction

    // Same rounding for the filter coefficient
    function automatic logic signed [PROD_W-1:0] rnd_alpha(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] biased;
        biased = x + (PROD_W'(1) << (ALPHA_BITS - 1));
        return biased >>> ALPHA_BITS;
    endfunction

    function automatic word_t sat_word(input logic signed [SUM_W-1:0] v);
        if ((~|v[SUM_W-1:WORD_W-1]) || (&v[SUM_W-1:WORD_W-1]))
            return v[WORD_W-1:0];
        else
            return v[SUM_W-1] ? WORD_MIN : WORD_MAX;
    endfunction

    // Low bound tested first; inverted limits: lo if v < lo, else hi
    function automatic word_t clamp_word(input logic signed [SUM_W-1:0] v,
                                         input word_t lo, input word_t hi);
        logic signed [SUM_W-1:0] lo_x;
        logic signed [SUM_W-1:0] hi_x;
        lo_x = SUM_W'(lo);
        hi_x = SUM_W'(hi);
        if (v < lo_x)
            return lo;
        else if (v > hi_x)
            return hi;
        else
            return v[WORD_W-1:0];
    endfunction

    // Controller state
    word_t iacc_reg;
    word_t prev_reg;
    word_t fr_reg;
    logic  rate_ready_reg;

    // Working registers
    word_t                    sp_reg;
    word_t                    ms_reg;
    word_t                    err_reg;
    word_t                    raw_reg;
    word_t                    frn_reg;
    word_t                    nint_reg;
    word_t                    drive_reg;
    logic signed [SUM_W-1:0]  pd_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [QUO_W-1:0]         nq_reg;
    logic [STEP_W-1:0]        rem_reg;
    logic                     neg_reg;

    // Combinational values
    step_t                      dt_eff;
    logic [WORD_W:0]            err_wide;
    word_t                      err_next;
    logic [WORD_W:0]            rdiff;
    logic [WORD_W:0]            rdiff_mag;
    logic [QUO_W-1:0]           nq_init;
    logic [QUO_W-1:0]           nq_work;
    logic [STEP_W-1:0]          rem_work;
    logic [STEP_W:0]            trial;
    logic                       q_hi;
    logic [WORD_W-1:0]          q_neg;
    word_t                      raw_next;
    logic signed [WORD_W:0]     rate_diff;
    logic signed [MUL_W-1:0]    mul_a;
    logic signed [MUL_W-1:0]    mul_b;
    logic signed [2*MUL_W-1:0]  mul_full;
    logic signed [PROD_W-1:0]   rnd_f_full;
    logic signed [PROD_W-1:0]   rnd_a_full;
    logic signed [SUM_W-1:0]    rnd_f;
    logic signed [SUM_W-1:0]    rnd_a;
    word_t                      frn_next;
    word_t                      nint_next;
    word_t                      drive_next;
    logic                       err_pos;

    assign dt_eff = (cfg.step_time == '0) ? STEP_FALLBACK : cfg.step_time;

    // Saturating error
    assign err_wide = {sp_reg[WORD_W-1], sp_reg} - {ms_reg[WORD_W-1], ms_reg};
    assign err_next = (err_wide[WORD_W] != err_wide[WORD_W-1])
                    ? (err_wide[WORD_W] ? WORD_MIN : WORD_MAX)
                    : err_wide[WORD_W-1:0];

    // Divider set-up: magnitude of (error - previous error), shifted up
    assign rdiff     = {err_reg[WORD_W-1], err_reg} - {prev_reg[WORD_W-1], prev_reg};
    assign rdiff_mag = rdiff[WORD_W] ? ('0 - rdiff) : rdiff;
    assign nq_init   = QUO_W'({rdiff_mag[WORD_W-1:0], {FRAC_BITS{1'b0}}});

    // Two restoring steps per cycle
    always_comb
    begin
        rem_work = rem_reg;
        nq_work  = nq_reg;
        trial    = '0;
        for (int k = 0; k < 2; k++)
        begin
            trial   = {rem_work, nq_work[QUO_W-1]};
            nq_work = {nq_work[QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, dt_eff})
            begin
                rem_work   = STEP_W'(trial - {1'b0, dt_eff});
                nq_work[0] = 1'b1;
            end
            else
            begin
                rem_work = trial[STEP_W-1:0];
            end
        end
    end

    // Signed, saturated quotient
    assign q_hi     = |nq_reg[QUO_W-1:WORD_W-1];
    assign q_neg    = '0 - nq_reg[WORD_W-1:0];
    assign raw_next = q_hi ? (neg_reg ? WORD_MIN : WORD_MAX)
                           : (neg_reg ? q_neg : nq_reg[WORD_W-1:0]);

    // Shared multiplier operand select
    assign rate_diff = {raw_reg[WORD_W-1], raw_reg} - {fr_reg[WORD_W-1], fr_reg};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MUL_FLT:
            begin
                mul_a = MUL_W'(rate_diff);
                mul_b = MUL_W'({1'b0, ALPHA_Q});
            end
            MUL_INT:
            begin
                mul_a = MUL_W'(err_reg);
                mul_b = MUL_W'({1'b0, dt_eff});
            end
            MUL_P:
            begin
                mul_a = MUL_W'(cfg.gain_p);
                mul_b = MUL_W'(err_reg);
            end
            MUL_D:
            begin
                mul_a = MUL_W'(cfg.gain_d);
                mul_b = MUL_W'(frn_reg);
            end
            MUL_I:
            begin
                mul_a = MUL_W'(cfg.gain_i);
                mul_b = MUL_W'(nint_reg);
            end
            MUL_I_OLD:
            begin
                mul_a = MUL_W'(cfg.gain_i);
                mul_b = MUL_W'(iacc_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // Rounded product from the previous cycle
    assign rnd_f_full = rnd_frac(prod_reg);
    assign rnd_a_full = rnd_alpha(prod_reg);
    assign rnd_f      = rnd_f_full[SUM_W-1:0];
    assign rnd_a      = rnd_a_full[SUM_W-1:0];

    assign frn_next   = sat_word(SUM_W'(fr_reg) + rnd_a);
    assign nint_next  = clamp_word(SUM_W'(iacc_reg) + rnd_f, cfg.integral_low, cfg.integral_high);
    assign drive_next = clamp_word(sum_reg, cfg.drive_low, cfg.drive_high);

    // Anti-windup test on the unclamped sum
    assign err_pos           = !err_reg[WORD_W-1] && (err_reg != '0);
    assign status.windup     = ((sum_reg > SUM_W'(cfg.drive_high)) && err_pos)
                            || ((sum_reg < SUM_W'(cfg.drive_low)) && err_reg[WORD_W-1]);
    assign status.rate_ready = rate_ready_reg;
    assign drive             = drive_reg;

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.mul_sel != MUL_NONE)
        begin
            prod_reg <= mul_full[PROD_W-1:0];
        end
        case (cmd.op)
            OP_LOAD:
            begin
                sp_reg <= setpoint;
                ms_reg <= measured;
            end
            OP_ERR:
            begin
                err_reg <= err_next;
                frn_reg <= '0;
            end
            OP_DIV_INIT:
            begin
                nq_reg  <= nq_init;
                rem_reg <= '0;
                neg_reg <= rdiff[WORD_W];
            end
            OP_DIV_STEP:
            begin
                nq_reg  <= nq_work;
                rem_reg <= rem_work;
            end
            OP_DIV_FIN:  raw_reg   <= raw_next;
            OP_FLT_ADD:  frn_reg   <= frn_next;
            OP_INT_ADD:  nint_reg  <= nint_next;
            OP_P:        pd_reg    <= rnd_f;
            OP_D:        pd_reg    <= pd_reg + rnd_f;
            OP_I:        sum_reg   <= pd_reg + rnd_f;
            OP_RETRY:    nint_reg  <= iacc_reg;
            OP_COMMIT:   drive_reg <= drive_next;
            OP_CLEAR:    drive_reg <= '0;
            default:     ;
        endcase
    end

    // Controller state, updated once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iacc_reg       <= '0;
            prev_reg       <= '0;
            fr_reg         <= '0;
            rate_ready_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_COMMIT:
                begin
                    iacc_reg       <= nint_reg;
                    prev_reg       <= err_reg;
                    fr_reg         <= frn_reg;
                    rate_ready_reg <= 1'b1;
                end
                OP_CLEAR:
                begin
                    iacc_reg       <= '0;
                    prev_reg       <= '0;
                    fr_reg         <= '0;
                    rate_ready_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Checks
    `ASSERT_NXT(a_commit_keeps_error, cmd.op == OP_COMMIT,
                rate_ready_reg && prev_reg == $past(err_reg), "commit lost error or rate flag")
    `ASSERT_NXT(a_retry_restores_integral, cmd.op == OP_RETRY,
                nint_reg == $past(iacc_reg), "windup retry did not restore integral")

endmodule

/* rtl/core/pidaw_ctrl.sv */
`include "assert_macros.svh"

module pidaw_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    input  logic                  sample_cmd,
    output logic                  sample_ready,
    output logic                  result_valid,
    input  logic                  result_ready,
    input  pidaw_pkg::dp_status_t status,
    output pidaw_pkg::ctrl_cmd_t  op_cmd
);
    import pidaw_pkg::*;

    ctrl_state_t      state_reg;
    ctrl_state_t      state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    // Output slot can take a result when empty or being emptied
    assign out_free     = !out_valid_reg || result_ready;
    assign result_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !result_ready;
        op_cmd.op      = OP_NONE;
        op_cmd.mul_sel = MUL_NONE;
        sample_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    op_cmd.op  = OP_LOAD;
                    state_next = sample_cmd ? S_CLEAR : S_ERR;
                end
            end
            S_ERR:
            begin
                op_cmd.op  = OP_ERR;
                state_next = status.rate_ready ? S_DIV_INIT : S_INT_MUL;
            end
            S_DIV_INIT:
            begin
                op_cmd.op  = OP_DIV_INIT;
                cnt_next   = '0;
                state_next = S_DIV_STEP;
            end
            S_DIV_STEP:
            begin
                op_cmd.op = OP_DIV_STEP;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_DIV_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DIV_FIN:
            begin
                op_cmd.op  = OP_DIV_FIN;
                state_next = S_FLT_MUL;
            end
            S_FLT_MUL:
            begin
                op_cmd.mul_sel = MUL_FLT;
                state_next     = S_FLT_ADD;
            end
            S_FLT_ADD:
            begin
                op_cmd.op  = OP_FLT_ADD;
                state_next = S_INT_MUL;
            end
            S_INT_MUL:
            begin
                op_cmd.mul_sel = MUL_INT;
                state_next     = S_INT_ADD;
            end
            S_INT_ADD:
            begin
                op_cmd.op      = OP_INT_ADD;
                op_cmd.mul_sel = MUL_P;
                state_next     = S_P;
            end
            S_P:
            begin
                op_cmd.op      = OP_P;
                op_cmd.mul_sel = MUL_D;
                state_next     = S_D;
            end
            S_D:
            begin
                op_cmd.op      = OP_D;
                op_cmd.mul_sel = MUL_I;
                state_next     = S_I;
            end
            S_I:
            begin
                op_cmd.op  = OP_I;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.windup)
                begin
                    op_cmd.op      = OP_RETRY;
                    op_cmd.mul_sel = MUL_I_OLD;
                    state_next     = S_I2;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_I2:
            begin
                op_cmd.op  = OP_I;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    op_cmd.op      = OP_COMMIT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                if (out_free)
                begin
                    op_cmd.op      = OP_CLEAR;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Checks
    `ASSERT_IMP(a_result_from_commit, $rose(out_valid_reg),
                $past(state_reg == S_DONE) || $past(state_reg == S_CLEAR),
                "result raised outside a commit state")
    `ASSERT_IMP(a_divider_full_length, state_reg == S_DIV_FIN,
                $past(state_reg == S_DIV_STEP) && $past(cnt_reg) == CNT_W'(DIV_STEPS - 1),
                "divider finished early")

endmodule

/* rtl/core/pid_controller_antiwindup.sv */
// PID controller, signed Q16.16, conditional integration against windup.
// Channels: sample (cmd, setpoint, measured) in, result (drive) out, and a
// register write channel cfg (index, data) that is always ready; registers
// should only be written while no transfer is in progress.
// Each sample transfer gives exactly one result transfer. An update also
// passes through S_I2 when the integral is rolled back for windup; the
// first update after reset or a clear skips the rate divider. A clear
// command gives a result of 0. The rate division runs two quotient bits a
// cycle, and one shared 34x34 multiplier serves the six products, so one
// item is worked on at a time.
// The next sample is taken as soon as the result sits in the output
// register; if the receiver stalls, that result is held and the following
// item waits in its final state until the register is free.
// Reset clears the integral, previous error, filtered rate and rate flag,
// and loads the register defaults.
module pid_controller_antiwindup (
    input  logic                  clk,
    input  logic                  rst_n,
    pidaw_sample_if.sink          sample,
    pidaw_result_if.source        result,
    pidaw_cfg_if.sink             cfg
);
    import pidaw_pkg::*;

    cfg_t       cfg_regs;
    ctrl_cmd_t  op_cmd;
    dp_status_t dp_status;

    pidaw_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .wr_ready (cfg.ready),
        .regs     (cfg_regs)
    );

    pidaw_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample.valid),
        .sample_cmd   (sample.cmd),
        .sample_ready (sample.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (dp_status),
        .op_cmd       (op_cmd)
    );

    pidaw_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (op_cmd),
        .cfg      (cfg_regs),
        .setpoint (sample.setpoint),
        .measured (sample.measured),
        .status   (dp_status),
        .drive    (result.drive)
    );

endmodule

/* sim/pid_controller_antiwindup_tb.sv */
`timescale 1ns / 1ps

module pid_controller_antiwindup_tb;
    import pidaw_pkg::*;

    localparam int ONE      = 1 << FRAC_BITS;   // 1.0 in Q16.16
    localparam int HOLD_OFF = 400;              // long receiver hold-off, cycles
    localparam int TAIL     = 60;               // settle time after the last result

    typedef struct packed {
        logic  cmd;
        word_t setpoint;
        word_t measured;
    } sample_t;

    logic clk;
    logic rst_n;

    pidaw_sample_if sample_bus ();
    pidaw_result_if result_bus ();
    pidaw_cfg_if    reg_bus ();

    pid_controller_antiwindup dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_bus),
        .result (result_bus),
        .cfg    (reg_bus)
    );

    // Pending samples, expected drives and bookkeeping
    sample_t samples_todo[$];
    word_t   drive_due[$];
    int      samples_queued = 0;
    int      drives_seen    = 0;
    int      mismatches     = 0;
    int      tx_idle_pct    = 0;
    int      rx_stall_pct   = 0;
    int      hold_left      = 0;
    logic    hold_go        = 1'b0;
    int      walk_sp        = 0;

    // Register copy seen by the predictor
    word_t p_gain   = CFG_RESET.gain_p;
    word_t i_gain   = CFG_RESET.gain_i;
    word_t d_gain   = CFG_RESET.gain_d;
    step_t dt_reg   = CFG_RESET.step_time;
    word_t int_lo   = CFG_RESET.integral_low;
    word_t int_hi   = CFG_RESET.integral_high;
    word_t drv_lo   = CFG_RESET.drive_low;
    word_t drv_hi   = CFG_RESET.drive_high;

    // Controller state seen by the predictor
    word_t integ_acc  = '0;
    word_t err_last   = '0;
    word_t rate_filt  = '0;
    logic  rate_valid = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Saturate to the 32-bit word range
    function automatic longint sat_word(input longint v);
        if (v > longint'(WORD_MAX))
            return longint'(WORD_MAX);
        if (v < longint'(WORD_MIN))
            return longint'(WORD_MIN);
        return v;
    endfunction

    // Drop fraction bits, nearest with ties upwards
    function automatic longint round_off(input longint v, input int unsigned sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    // Low bound tested first; inverted limits: lo if v < lo, else hi
    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Expected drive for one sample; advances the predicted state
    function automatic word_t pid_drive(input logic clr, input word_t sp, input word_t pv);
        longint err, dt, diff, raw, nudge, integ_new, p_term, d_term, total;
        if (clr)
        begin
            integ_acc  = '0;
            err_last   = '0;
            rate_filt  = '0;
            rate_valid = 1'b0;
            return '0;
        end
        err = sat_word(longint'(sp) - longint'(pv));
        dt  = longint'(dt_reg);
        if (dt == 0)
            dt = longint'(STEP_FALLBACK);

        // filtered derivative, skipped on the first update
        if (!rate_valid)
        begin
            rate_filt  = '0;
            rate_valid = 1'b1;
        end
        else
        begin
            diff      = err - longint'(err_last);
            raw       = sat_word((diff * (longint'(1) <<< FRAC_BITS)) / dt);
            nudge     = round_off((raw - longint'(rate_filt)) * DERIV_FILTER_ALPHA,
                                  ALPHA_BITS);
            rate_filt = word_t'(sat_word(longint'(rate_filt) + nudge));
        end

        integ_new = clamp_to(longint'(integ_acc) + round_off(err * dt, FRAC_BITS),
                             longint'(int_lo), longint'(int_hi));
        p_term = round_off(longint'(p_gain) * err, FRAC_BITS);
        d_term = round_off(longint'(d_gain) * longint'(rate_filt), FRAC_BITS);
        total  = p_term + round_off(longint'(i_gain) * integ_new, FRAC_BITS) + d_term;

        // conditional integration: hold the integral while pushing into a limit
        if ((total > longint'(drv_hi) && err > 0) || (total < longint'(drv_lo) && err < 0))
        begin
            integ_new = longint'(integ_acc);
            total     = p_term + round_off(longint'(i_gain) * integ_new, FRAC_BITS) + d_term;
        end

        integ_acc = word_t'(integ_new);
        err_last  = word_t'(err);
        return word_t'(clamp_to(total, longint'(drv_lo), longint'(drv_hi)));
    endfunction

    // Sample driver: predicts on each transfer, then offers the next item
    always @(posedge clk or negedge rst_n)
    begin : sample_driver
        sample_t nxt;
        if (!rst_n)
        begin
            sample_bus.valid    <= 1'b0;
            sample_bus.cmd      <= 1'b0;
            sample_bus.setpoint <= '0;
            sample_bus.measured <= '0;
        end
        else
        begin
            if (sample_bus.valid && sample_bus.ready)
                drive_due.push_back(pid_drive(sample_bus.cmd, sample_bus.setpoint,
                                              sample_bus.measured));
            if (!sample_bus.valid || sample_bus.ready)
            begin
                if (samples_todo.size() > 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    nxt = samples_todo.pop_front();
                    sample_bus.valid    <= 1'b1;
                    sample_bus.cmd      <= nxt.cmd;
                    sample_bus.setpoint <= nxt.setpoint;
                    sample_bus.measured <= nxt.measured;
                end
                else
                    sample_bus.valid <= 1'b0;
            end
        end
    end

    // Receiver hold-off counter
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_go)
            hold_left <= HOLD_OFF;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Result monitor: checks each drive transfer against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin : drive_monitor
        word_t want;
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                drives_seen++;
                if (drive_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t unexpected drive transfer: expected none, got %0d",
                             $time, result_bus.drive);
                end
                else
                begin
                    want = drive_due.pop_front();
                    if (result_bus.drive !== want)
                    begin
                        mismatches++;
                        $display("%0t drive mismatch: expected %0d, got %0d",
                                 $time, want, result_bus.drive);
                    end
                end
            end
            result_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [WORD_W-1:0] val);
        @(posedge clk);
        reg_bus.valid <= 1'b1;
        reg_bus.index <= idx;
        reg_bus.data  <= val;
        do
            @(posedge clk);
        while (!reg_bus.ready);
        reg_bus.valid <= 1'b0;
        case (idx)
            REG_GAIN_P:        p_gain = val;
            REG_GAIN_I:        i_gain = val;
            REG_GAIN_D:        d_gain = val;
            REG_STEP_TIME:     dt_reg = val[STEP_W-1:0];
            REG_INTEGRAL_LOW:  int_lo = val;
            REG_INTEGRAL_HIGH: int_hi = val;
            REG_DRIVE_LOW:     drv_lo = val;
            REG_DRIVE_HIGH:    drv_hi = val;
            default: ;
        endcase
    endtask

    task automatic load_regs(input cfg_t c);
        write_reg(REG_GAIN_P, c.gain_p);
        write_reg(REG_GAIN_I, c.gain_i);
        write_reg(REG_GAIN_D, c.gain_d);
        write_reg(REG_STEP_TIME, WORD_W'(c.step_time));
        write_reg(REG_INTEGRAL_LOW, c.integral_low);
        write_reg(REG_INTEGRAL_HIGH, c.integral_high);
        write_reg(REG_DRIVE_LOW, c.drive_low);
        write_reg(REG_DRIVE_HIGH, c.drive_high);
    endtask

    // Every sample gives one drive, so idle means counts agree
    task automatic wait_idle();
        do
            @(posedge clk);
        while (drives_seen < samples_queued);
    endtask

    function automatic void queue_sample(input logic c, input word_t sp, input word_t pv);
        sample_t s;
        s.cmd      = c;
        s.setpoint = sp;
        s.measured = pv;
        samples_todo.push_back(s);
        samples_queued++;
    endfunction

    function automatic word_t edge_word();
        case ($urandom_range(3))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    function automatic word_t rand_gain();
        case ($urandom_range(3))
            0:       return word_t'(int'($urandom_range(8 * ONE)) - 4 * ONE);
            1:       return word_t'(int'($urandom_range(2 * ONE)) - ONE);
            2:       return word_t'($urandom);
            default: return '0;
        endcase
    endfunction

    // Limit pair, mostly ordered, now and then inverted
    function automatic void rand_limits(output word_t lo, output word_t hi);
        word_t a, b;
        if ($urandom_range(4) == 0)
        begin
            a = $urandom;
            b = $urandom;
        end
        else
        begin
            a = word_t'(int'($urandom_range(200000000)) - 100000000);
            b = word_t'(int'($urandom_range(200000000)) - 100000000);
        end
        if (a > b && $urandom_range(6) != 0)
        begin
            lo = b;
            hi = a;
        end
        else
        begin
            lo = a;
            hi = b;
        end
    endfunction

    function automatic cfg_t rand_cfg();
        cfg_t c;
        c.gain_p = rand_gain();
        c.gain_i = rand_gain();
        c.gain_d = rand_gain();
        case ($urandom_range(3))
            0:       c.step_time = step_t'(1);
            1:       c.step_time = step_t'(65536);
            2:       c.step_time = step_t'($urandom_range(1, 65536));
            default: c.step_time = step_t'($urandom_range(1, 2000));
        endcase
        rand_limits(c.integral_low, c.integral_high);
        rand_limits(c.drive_low, c.drive_high);
        return c;
    endfunction

    // Mostly tracking a setpoint that jumps at times, plus noise and clears
    function automatic void queue_walk_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 4)
            queue_sample(1'b1, $urandom, $urandom);
        else if (pick < 14)
            queue_sample(1'b0, $urandom, $urandom);
        else if (pick < 20)
            queue_sample(1'b0, edge_word(), edge_word());
        else
        begin
            if ($urandom_range(7) == 0)
                walk_sp = int'($urandom_range(65536000)) - 32768000;
            queue_sample(1'b0, walk_sp, walk_sp + int'($urandom_range(40 * ONE)) - 20 * ONE);
        end
    endfunction

    // Watchdog
    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        cfg_t setting;
        int   ph;
        rst_n               = 1'b0;
        sample_bus.valid    = 1'b0;
        sample_bus.cmd      = 1'b0;
        sample_bus.setpoint = '0;
        sample_bus.measured = '0;
        result_bus.ready    = 1'b0;
        reg_bus.valid       = 1'b0;
        reg_bus.index       = REG_GAIN_P;
        reg_bus.data        = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: first update, error saturation both ways, clear
        queue_sample(1'b0, ONE, 0);
        queue_sample(1'b0, WORD_MAX, WORD_MIN);
        queue_sample(1'b0, WORD_MIN, WORD_MAX);
        queue_sample(1'b0, 0, 0);
        queue_sample(1'b1, 0, 0);
        queue_sample(1'b0, -5 * ONE / 2, 13 * ONE / 4);
        wait_idle();

        // Tight output limits: windup hold both ways, derivative saturation
        setting = '{gain_p: ONE / 2, gain_i: 2 * ONE, gain_d: ONE / 4,
                    step_time: step_t'(ONE), integral_low: -50 * ONE,
                    integral_high: 50 * ONE, drive_low: -10 * ONE, drive_high: 10 * ONE};
        load_regs(setting);
        queue_sample(1'b1, 0, 0);
        queue_sample(1'b0, 20 * ONE, 0);
        queue_sample(1'b0, 20 * ONE, 0);
        queue_sample(1'b0, 5 * ONE, 0);
        queue_sample(1'b0, -30 * ONE, 0);
        queue_sample(1'b0, -30 * ONE, 0);
        queue_sample(1'b0, WORD_MAX, WORD_MIN);
        queue_sample(1'b0, WORD_MIN, WORD_MAX);
        wait_idle();

        // Inverted limits, extreme gains, shortest period
        setting = '{gain_p: WORD_MAX, gain_i: WORD_MIN, gain_d: WORD_MAX,
                    step_time: step_t'(1), integral_low: 5 * ONE,
                    integral_high: -5 * ONE, drive_low: 3 * ONE, drive_high: -3 * ONE};
        load_regs(setting);
        queue_sample(1'b1, WORD_MAX, WORD_MIN);
        queue_sample(1'b0, WORD_MAX, 0);
        queue_sample(1'b0, 0, WORD_MIN);
        queue_sample(1'b0, -1, -1);
        queue_sample(1'b0, WORD_MIN, 0);
        queue_sample(1'b0, 32'h1234_5678, 32'hF123_4568);
        wait_idle();

        // Receiver holds off while the sender keeps offering: input must stall
        load_regs(rand_cfg());
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
        repeat (24) queue_walk_sample();
        wait_idle();

        // Random phases over extreme and random settings and idling patterns
        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: setting = '{gain_p: WORD_MAX, gain_i: WORD_MAX, gain_d: WORD_MAX,
                               step_time: step_t'(65536), integral_low: WORD_MIN,
                               integral_high: WORD_MAX, drive_low: WORD_MIN,
                               drive_high: WORD_MAX};
                1: setting = '{gain_p: WORD_MIN, gain_i: WORD_MIN, gain_d: WORD_MIN,
                               step_time: step_t'(1), integral_low: WORD_MAX,
                               integral_high: WORD_MIN, drive_low: WORD_MAX,
                               drive_high: WORD_MIN};
                default: setting = rand_cfg();
            endcase
            load_regs(setting);
            case (ph % 4)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct  = 58;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 58;
                end
                default:
                begin
                    tx_idle_pct  = 27;
                    rx_stall_pct = 27;
                end
            endcase
            repeat (80) queue_walk_sample();
            wait_idle();
        end

        repeat (TAIL) @(posedge clk);
        if (mismatches == 0 && drive_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* pid_controller_antiwindup.f */
+incdir+rtl/core
rtl/core/pidaw_pkg.sv
rtl/core/pidaw_sample_if.sv
rtl/core/pidaw_result_if.sv
rtl/core/pidaw_cfg_if.sv
rtl/core/pidaw_cfg.sv
rtl/core/pidaw_dp.sv
rtl/core/pidaw_ctrl.sv
rtl/core/pid_controller_antiwindup.sv
sim/pid_controller_antiwindup_tb.sv
